@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every user clocks on clock and
// resets on reset, so both are taken from the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LPE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// An implication checked in the same cycle.
`define LPE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// An implication checked in the next cycle.
`define LPE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lpe_pkg.sv @@
package lpe_pkg;

   // Field widths.
   localparam int BYTE_W       = 8;
   localparam int COLOR_W      = 24;
   localparam int PTR_W        = 13;
   localparam int BIT_POS_W    = 5;
   localparam int BITS_PER_LED = 24;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LED_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_DUTY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_DUTY    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_SLOTS = 2'd3;

   // Register values after reset.
   localparam logic [BYTE_W-1:0] LED_COUNT_RST   = 8'd8;
   localparam logic [BYTE_W-1:0] HIGH_DUTY_RST   = 8'd50;
   localparam logic [BYTE_W-1:0] LOW_DUTY_RST    = 8'd25;
   localparam logic [BYTE_W-1:0] RESET_SLOTS_RST = 8'd64;

   // Request mode codes.
   localparam logic MODE_SET  = 1'b0;
   localparam logic MODE_PULL = 1'b1;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Reciprocal of three for the slot index split (exact below 1024 * 2).
   localparam int RECIP3_MUL   = 683;
   localparam int RECIP3_SHIFT = 11;

   typedef struct packed {
      logic [BYTE_W-1:0] led_count;
      logic [BYTE_W-1:0] high_duty;
      logic [BYTE_W-1:0] low_duty;
      logic [BYTE_W-1:0] reset_slots;
   } lpe_cfg_type;

   typedef enum logic [1:0] {
      CMD_SET,
      CMD_REJECT,
      CMD_PULL
   } lpe_cmd_kind_type;

   typedef struct packed {
      lpe_cmd_kind_type     kind;
      logic [BYTE_W-1:0]    first_idx;
      logic [BYTE_W-1:0]    last_idx;
      logic [COLOR_W-1:0]   color;
   } lpe_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic frame_active;
   } lpe_back_status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WRITE,
      BK_DIV,
      BK_READ,
      BK_RESP
   } lpe_back_state_type;

endpackage

@@ hdl/lpe_queue.sv @@
`include "assert_macros.svh"

module lpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lpe_pkg::lpe_cmd_type push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lpe_pkg::lpe_cmd_type pop_cmd
);
   import lpe_pkg::*;

   lpe_cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    push_fire;
   logic                    pop_fire;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The fill count never passes the depth.
   `LPE_ASSERT(a_count_bound, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")
   // Read and write pointers agree whenever the queue is empty or full.
   `LPE_ASSERT_IMPL(a_ptr_match, count_ff == '0 || count_ff == QUEUE_CNT_W'(QUEUE_DEPTH),
      wr_ptr_ff == rd_ptr_ff, "queue pointers disagree with count")
   // A lone push grows the count by exactly one.
   `LPE_ASSERT_NEXT(a_push_grows, push_fire && !pop_fire,
      count_ff == $past(count_ff) + QUEUE_CNT_W'(1), "queue count did not grow")

endmodule

@@ hdl/lpe_front.sv @@
module lpe_front (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [7:0]                  req_first_led,
   input  logic [7:0]                  req_last_led,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   input  lpe_pkg::lpe_cfg_type        cfg,
   input  lpe_pkg::lpe_back_status_type back_status,
   output logic                        push_valid,
   input  logic                        push_ready,
   output lpe_pkg::lpe_cmd_type        push_cmd
);
   import lpe_pkg::*;

   logic range_bad;

   // Requests wait until the color store has been cleared after reset.
   assign req_ready  = back_status.clear_done && push_ready;
   assign push_valid = req_valid && back_status.clear_done;

   // A range is rejected when it starts at zero, runs past the strip or is reversed.
   assign range_bad = (req_first_led == '0) || (req_last_led > cfg.led_count) ||
                      (req_first_led > req_last_led);

   // Classify the request and convert the range to zero-based indexes.
   always_comb begin
      push_cmd.first_idx = req_first_led - BYTE_W'(1);
      push_cmd.last_idx  = req_last_led - BYTE_W'(1);
      push_cmd.color     = {req_red, req_green, req_blue};
      if (req_mode == MODE_PULL) begin
         push_cmd.kind = CMD_PULL;
      end else if (range_bad) begin
         push_cmd.kind = CMD_REJECT;
      end else begin
         push_cmd.kind = CMD_SET;
      end
   end

endmodule

@@ hdl/lpe_back.sv @@
`include "assert_macros.svh"

module lpe_back #(
   parameter int MAX_LEDS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpe_pkg::lpe_cfg_type        cfg,
   input  logic                        q_valid,
   input  lpe_pkg::lpe_cmd_type        q_cmd,
   output logic                        q_pop,
   output lpe_pkg::lpe_back_status_type back_status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_range_error,
   output logic [7:0]                  rsp_duty,
   output logic                        rsp_slot_valid,
   output logic                        rsp_frame_last
);
   import lpe_pkg::*;

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   // Color store, one word per LED.
   logic [COLOR_W-1:0]   color_mem_ff [MAX_LEDS];
   logic [COLOR_W-1:0]   rd_data_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [COLOR_W-1:0]   mem_wdata;

   // Control state.
   lpe_back_state_type   state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic                 active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Per-command working registers.
   logic [BYTE_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [BYTE_W-1:0]    wr_last_ff, wr_last_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic [PTR_W-1:0]     d_ff, d_in;
   logic [BYTE_W-1:0]    led_ff, led_in;
   logic [BIT_POS_W-1:0] rem_ff, rem_in;
   logic                 ok_ff, ok_in;
   logic                 err_ff, err_in;
   logic                 data_ff, data_in;
   logic                 slot_ff, slot_in;
   logic                 flast_ff, flast_in;

   // Response register.
   logic                 rsp_err_ff, rsp_err_in;
   logic [BYTE_W-1:0]    rsp_duty_ff, rsp_duty_in;
   logic                 rsp_slot_ff, rsp_slot_in;
   logic                 rsp_flast_ff, rsp_flast_in;

   // Slot arithmetic.
   logic [PTR_W-1:0]     total;
   logic [PTR_W-1:0]     ptr_next;
   logic [9:0]           d_div8;
   logic [19:0]          recip_prod;
   logic [BYTE_W-1:0]    quot;
   logic [PTR_W-1:0]     rem_full;
   logic [BIT_POS_W-1:0] bit_pos;
   logic                 color_bit;
   logic                 out_free;
   logic                 wr_in_range;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign total       = PTR_W'(cfg.reset_slots) +
                        PTR_W'(cfg.led_count) * PTR_W'(BITS_PER_LED);
   assign ptr_next    = ptr_ff + PTR_W'(1);
   assign wr_in_range = 32'(wr_idx_ff) < MAX_LEDS;

   // Data slot index split into LED and bit: d / 24 is (d / 8) / 3.
   assign d_div8     = d_ff[PTR_W-1:3];
   assign recip_prod = 20'(d_div8) * 20'(RECIP3_MUL);
   assign quot       = recip_prod[RECIP3_SHIFT +: BYTE_W];
   assign rem_full   = d_ff - PTR_W'(led_ff) * PTR_W'(BITS_PER_LED);

   // Color bits go out most significant first.
   assign bit_pos   = BIT_POS_W'(BITS_PER_LED - 1) - rem_ff;
   assign color_bit = ok_ff && rd_data_ff[bit_pos];

   assign back_status.clear_done   = (state_ff != BK_CLEAR);
   assign back_status.frame_active = active_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_error = rsp_err_ff;
   assign rsp_duty        = rsp_duty_ff;
   assign rsp_slot_valid  = rsp_slot_ff;
   assign rsp_frame_last  = rsp_flast_ff;

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      active_in    = active_ff;
      wr_idx_in    = wr_idx_ff;
      wr_last_in   = wr_last_ff;
      color_in     = color_ff;
      d_in         = d_ff;
      led_in       = led_ff;
      rem_in       = rem_ff;
      ok_in        = ok_ff;
      err_in       = err_ff;
      data_in      = data_ff;
      slot_in      = slot_ff;
      flast_in     = flast_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_err_in   = rsp_err_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_flast_in = rsp_flast_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;

      unique case (state_ff)
         BK_CLEAR: begin
            // Zero one store entry per cycle after reset.
            mem_we = 1'b1;
            if (clr_ff == AW'(MAX_LEDS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               err_in   = 1'b0;
               data_in  = 1'b0;
               slot_in  = 1'b0;
               flast_in = 1'b0;
               state_in = BK_RESP;
               unique case (q_cmd.kind)
                  CMD_REJECT: begin
                     err_in = 1'b1;
                  end
                  CMD_SET: begin
                     active_in  = 1'b1;
                     ptr_in     = '0;
                     wr_idx_in  = q_cmd.first_idx;
                     wr_last_in = q_cmd.last_idx;
                     color_in   = q_cmd.color;
                     state_in   = BK_WRITE;
                  end
                  CMD_PULL: begin
                     if (active_ff) begin
                        if (ptr_ff >= total) begin
                           // The frame was shortened under the pointer.
                           active_in = 1'b0;
                           ptr_in    = '0;
                        end else begin
                           slot_in = 1'b1;
                           if (ptr_next == total) begin
                              flast_in  = 1'b1;
                              active_in = 1'b0;
                              ptr_in    = '0;
                           end else begin
                              ptr_in = ptr_next;
                           end
                           if (ptr_ff >= PTR_W'(cfg.reset_slots)) begin
                              data_in  = 1'b1;
                              d_in     = ptr_ff - PTR_W'(cfg.reset_slots);
                              state_in = BK_DIV;
                           end
                        end
                     end
                  end
                  default: begin
                     err_in = 1'b1;
                  end
               endcase
            end
         end
         BK_WRITE: begin
            // Walk the range one LED per cycle.
            mem_we    = wr_in_range;
            mem_waddr = AW'(wr_idx_ff);
            mem_wdata = color_ff;
            if (wr_idx_ff == wr_last_ff) begin
               state_in = BK_RESP;
            end else begin
               wr_idx_in = wr_idx_ff + BYTE_W'(1);
            end
         end
         BK_DIV: begin
            led_in   = quot;
            state_in = BK_READ;
         end
         BK_READ: begin
            // The store read of led_ff is registered into rd_data_ff here, ready for BK_RESP.
            rem_in   = rem_full[BIT_POS_W-1:0];
            ok_in    = 32'(led_ff) < MAX_LEDS;
            state_in = BK_RESP;
         end
         BK_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_slot_in  = slot_ff;
               rsp_flast_in = flast_ff;
               if (data_ff) begin
                  rsp_duty_in = color_bit ? cfg.high_duty : cfg.low_duty;
               end else begin
                  rsp_duty_in = '0;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         ptr_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      wr_idx_ff    <= wr_idx_in;
      wr_last_ff   <= wr_last_in;
      color_ff     <= color_in;
      d_ff         <= d_in;
      led_ff       <= led_in;
      rem_ff       <= rem_in;
      ok_ff        <= ok_in;
      err_ff       <= err_in;
      data_ff      <= data_in;
      slot_ff      <= slot_in;
      flast_ff     <= flast_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_flast_ff <= rsp_flast_in;
   end

   // Color store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         color_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= color_mem_ff[AW'(led_ff)];
   end

   // An idle strip always restarts from the first slot.
   `LPE_ASSERT_IMPL(a_idle_ptr_zero, !active_ff, ptr_ff == '0, "pointer set while idle")
   // A range walk never passes its last LED.
   `LPE_ASSERT_IMPL(a_walk_bound, state_ff == BK_WRITE, wr_idx_ff <= wr_last_ff,
      "range walk overran")
   // Data slots only come from an active frame slot.
   `LPE_ASSERT_IMPL(a_data_has_slot, state_ff == BK_RESP && data_ff, slot_ff,
      "data slot without a valid slot")

endmodule

@@ hdl/led_strip_pulse_encoder.sv @@
// LED strip pulse encoder.
// Requests arrive on the req_ channel (valid/ready). Mode set writes one
// color to a 1-based inclusive LED range and restarts the frame; a bad range
// answers with rsp_range_error and changes nothing. Mode pull returns the
// next PWM compare value on rsp_duty: reset slots at duty 0, then 24 data
// slots per LED (red, green, blue, most significant bit first). Every request
// yields exactly one response on the rsp_ channel, in request order.
// Registers are written through csr_write_en, csr_index and csr_wdata.
// From acceptance, a pull that lands in a data slot passes the index split, the
// store read and the response state before rsp_valid; a latch-slot pull, a pull
// outside a frame or a rejected set goes straight to the response, and a good
// set first walks its whole range, since the range walk uses the single store
// write port. The back end works on one request at a time, so it takes no new
// request before it has answered the last; a two-entry queue lets the front
// accept while the back works.
// After reset the color store is cleared one entry per cycle with req_ready
// low. When the receiver holds rsp_ready low, the response stays registered,
// the queue fills and then req_ready drops.
module led_strip_pulse_encoder #(
   parameter int MAX_LEDS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_first_led,
   input  logic [7:0] req_last_led,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_range_error,
   output logic [7:0] rsp_duty,
   output logic       rsp_slot_valid,
   output logic       rsp_frame_last,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import lpe_pkg::*;

   lpe_cfg_type         cfg_ff, cfg_in;
   lpe_back_status_type back_status;
   lpe_cmd_type         push_cmd;
   lpe_cmd_type         q_cmd;
   logic                push_valid;
   logic                push_ready;
   logic                q_valid;
   logic                q_pop;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LED_COUNT:   cfg_in.led_count   = csr_wdata;
            CSR_HIGH_DUTY:   cfg_in.high_duty   = csr_wdata;
            CSR_LOW_DUTY:    cfg_in.low_duty    = csr_wdata;
            CSR_RESET_SLOTS: cfg_in.reset_slots = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count   <= LED_COUNT_RST;
         cfg_ff.high_duty   <= HIGH_DUTY_RST;
         cfg_ff.low_duty    <= LOW_DUTY_RST;
         cfg_ff.reset_slots <= RESET_SLOTS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpe_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_first_led (req_first_led),
      .req_last_led  (req_last_led),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .cfg           (cfg_ff),
      .back_status   (back_status),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_cmd      (push_cmd)
   );

   lpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_cmd    (q_cmd)
   );

   lpe_back #(
      .MAX_LEDS (MAX_LEDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .back_status     (back_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_error (rsp_range_error),
      .rsp_duty        (rsp_duty),
      .rsp_slot_valid  (rsp_slot_valid),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule
